// ===== rtl/svv_pkg.sv =====
// ----------------------------------------------------------------------------
// svv_pkg
// Types and constants shared by the semantic version string validator.
// ----------------------------------------------------------------------------
package svv_pkg;

   localparam int MAX_LENGTH_DEFAULT = 255;
   localparam int MIN_LENGTH         = 5;

   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;

   typedef enum logic [2:0] {
      PH_MAJOR = 3'd0,
      PH_MINOR = 3'd1,
      PH_PATCH = 3'd2,
      PH_PRE   = 3'd3,
      PH_BUILD = 3'd4
   } svv_phase_type;

   typedef struct packed {
      logic       is_valid;
      logic [7:0] version_length;
   } svv_result_type;

   typedef struct packed {
      logic       step;
      logic       last_char;
      logic [7:0] char_byte;
   } svv_char_type;

endpackage

// ===== rtl/svv_if.sv =====
// ----------------------------------------------------------------------------
// svv_req_if / svv_rsp_if
// Valid/ready channels for characters in and check results out.
// ----------------------------------------------------------------------------
interface svv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       last_char;

   modport source (output valid, output char_byte, output last_char, input ready);
   modport sink   (input valid, input char_byte, input last_char, output ready);
endinterface

interface svv_rsp_if;
   logic       valid;
   logic       ready;
   logic       is_valid;
   logic [7:0] version_length;

   modport source (output valid, output is_valid, output version_length, input ready);
   modport sink   (input valid, input is_valid, input version_length, output ready);
endinterface

// ===== rtl/semver_string_validator_unit.sv =====
// ----------------------------------------------------------------------------
// semver_string_validator_unit
// Checks a version string, one character per transaction, against the
// MAJOR.MINOR.PATCH[-pre][+build] form and reports validity and length.
// ----------------------------------------------------------------------------
// result path: the last character is held in the input register, then parsed into the result register
// throughput: one character per cycle while no untaken result holds up a last character
// a result not yet taken holds the next last character and the input behind it
// reset: synchronous, clears the parse state and both stage valid flags
module semver_string_validator_unit
   import svv_pkg::*;
#(
   parameter int MaxLength = MAX_LENGTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   svv_req_if.sink    req_chan,
   svv_rsp_if.source  rsp_chan
);

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_char_ff;
   logic           in_last_ff;
   logic           in_move;
   logic           req_take;
   logic           rsp_valid_ff, rsp_valid_in;
   svv_result_type rsp_data_ff;
   svv_result_type parse_result;
   svv_char_type   parse_char;

   assign in_move  = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || in_move;
   assign req_take = req_chan.valid && req_chan.ready;
   assign in_valid_in = req_take ? 1'b1 : (in_move ? 1'b0 : in_valid_ff);

   assign parse_char.step      = in_move;
   assign parse_char.last_char = in_last_ff;
   assign parse_char.char_byte = in_char_ff;

   svv_parse #(
      .MaxLength (MaxLength)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .char_in (parse_char),
      .result  (parse_result)
   );

   assign rsp_valid_in = (in_move && in_last_ff) ? 1'b1
                         : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_chan.char_byte;
         in_last_ff <= req_chan.last_char;
      end
      if (in_move && in_last_ff) begin
         rsp_data_ff <= parse_result;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.is_valid       = rsp_data_ff.is_valid;
   assign rsp_chan.version_length = rsp_data_ff.version_length;

endmodule

// ===== rtl/svv_parse.sv =====
// ----------------------------------------------------------------------------
// svv_parse
// Parse state and per-character transition; gives the result at the last
// character and then returns to the start state.
// ----------------------------------------------------------------------------
module svv_parse
   import svv_pkg::*;
#(
   parameter int MaxLength = MAX_LENGTH_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  svv_char_type   char_in,
   output svv_result_type result
);

   localparam int CntW = $clog2(MaxLength + 1);

   svv_phase_type   phase_ff, phase_in, phase_step;
   logic            lead_zero_ff, lead_zero_in, lead_zero_step;
   logic            nonempty_ff, nonempty_in, nonempty_step;
   logic            failed_ff, failed_in, failed_step;
   logic [CntW-1:0] count_ff, count_in, count_step;
   logic            at_max;
   logic            is_digit;
   logic            is_ident;
   logic [CntW+7:0] count_ext;
   logic [7:0]      c;

   assign c        = char_in.char_byte;
   assign at_max   = count_ff >= CntW'(MaxLength);
   assign is_digit = c inside {[8'h30:8'h39]};
   assign is_ident = is_digit || (c inside {[8'h41:8'h5A], [8'h61:8'h7A], CHAR_MINUS});

   // next state for one character
   always_comb begin
      phase_step     = phase_ff;
      lead_zero_step = lead_zero_ff;
      nonempty_step  = nonempty_ff;
      failed_step    = failed_ff || at_max;
      count_step     = at_max ? count_ff : count_ff + CntW'(1);
      case (phase_ff)
         PH_MAJOR, PH_MINOR, PH_PATCH: begin
            if (is_digit) begin
               if (!nonempty_ff) begin
                  nonempty_step  = 1'b1;
                  lead_zero_step = (c == CHAR_ZERO);
               end else if (lead_zero_ff) begin
                  failed_step = 1'b1;
               end
            end else if (!nonempty_ff) begin
               failed_step = 1'b1;
            end else if (c == CHAR_DOT && phase_ff != PH_PATCH) begin
               phase_step     = (phase_ff == PH_MAJOR) ? PH_MINOR : PH_PATCH;
               nonempty_step  = 1'b0;
               lead_zero_step = 1'b0;
            end else if (c == CHAR_MINUS && phase_ff == PH_PATCH) begin
               phase_step     = PH_PRE;
               nonempty_step  = 1'b0;
               lead_zero_step = 1'b0;
            end else if (c == CHAR_PLUS && phase_ff == PH_PATCH) begin
               phase_step     = PH_BUILD;
               nonempty_step  = 1'b0;
               lead_zero_step = 1'b0;
            end else begin
               failed_step = 1'b1;
            end
         end
         PH_PRE, PH_BUILD: begin
            if (is_ident) begin
               nonempty_step = 1'b1;
            end else if (!nonempty_ff) begin
               failed_step = 1'b1;
            end else if (c == CHAR_DOT) begin
               nonempty_step  = 1'b0;
               lead_zero_step = 1'b0;
            end else if (c == CHAR_PLUS && phase_ff == PH_PRE) begin
               phase_step     = PH_BUILD;
               nonempty_step  = 1'b0;
               lead_zero_step = 1'b0;
            end else begin
               failed_step = 1'b1;
            end
         end
         default: begin
            failed_step = 1'b1;
         end
      endcase
   end

   // register update, back to start after the last character
   always_comb begin
      phase_in     = phase_ff;
      lead_zero_in = lead_zero_ff;
      nonempty_in  = nonempty_ff;
      failed_in    = failed_ff;
      count_in     = count_ff;
      if (char_in.step) begin
         if (char_in.last_char) begin
            phase_in     = PH_MAJOR;
            lead_zero_in = 1'b0;
            nonempty_in  = 1'b0;
            failed_in    = 1'b0;
            count_in     = '0;
         end else begin
            phase_in     = phase_step;
            lead_zero_in = lead_zero_step;
            nonempty_in  = nonempty_step;
            failed_in    = failed_step;
            count_in     = count_step;
         end
      end
   end

   // result for the last character
   always_comb begin
      count_ext       = {8'b0, count_step};
      result.is_valid = !failed_step && (count_step >= CntW'(MIN_LENGTH)) && nonempty_step
                        && (phase_step == PH_PATCH || phase_step == PH_PRE
                            || phase_step == PH_BUILD);
      result.version_length = result.is_valid ? count_ext[7:0] : 8'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_MAJOR;
         lead_zero_ff <= 1'b0;
         nonempty_ff  <= 1'b0;
         failed_ff    <= 1'b0;
         count_ff     <= '0;
      end else begin
         phase_ff     <= phase_in;
         lead_zero_ff <= lead_zero_in;
         nonempty_ff  <= nonempty_in;
         failed_ff    <= failed_in;
         count_ff     <= count_in;
      end
   end

endmodule
